/* rtl/cbp_pkg.sv */
// shared types, register codes and width helpers for the coefficient bit packer
package cbp_pkg;

	localparam int ACC_W    = 20;
	localparam int COUNT_W  = 5;
	localparam int NRES_W   = 4;
	localparam int DATA_W   = 16;
	localparam int COEF_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_MODE = 2'd0,
		REG_DIRECTION  = 2'd1
	} reg_index_t;

	typedef enum logic [1:0] {
		WIDTH_1  = 2'd0,
		WIDTH_4  = 2'd1,
		WIDTH_10 = 2'd2,
		WIDTH_13 = 2'd3
	} width_mode_t;

	typedef enum logic {
		DIR_PACK   = 1'b0,
		DIR_UNPACK = 1'b1
	} dir_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_in;
		logic              stream_last_in;
	} item_beat_t;

	typedef struct packed {
		logic [COEF_W-1:0] data_out;
		logic              run_end;
		logic              stream_last_out;
	} result_beat_t;

	// one classified item: the bits to emit and how many results they give
	typedef struct packed {
		logic [ACC_W-1:0]  bits;
		logic [NRES_W-1:0] nres;
		width_mode_t       mode;
		dir_t              dir;
		logic              last;
	} entry_t;

	function automatic logic [3:0] width_bits(input width_mode_t mode);
		logic [3:0] w;
		case (mode)
			WIDTH_1:  w = 4'd1;
			WIDTH_4:  w = 4'd4;
			WIDTH_10: w = 4'd10;
			WIDTH_13: w = 4'd13;
			default:  w = 4'd13;
		endcase
		return w;
	endfunction

	function automatic logic [COEF_W-1:0] coef_mask(input width_mode_t mode);
		logic [COEF_W-1:0] m;
		case (mode)
			WIDTH_1:  m = 13'h0001;
			WIDTH_4:  m = 13'h000f;
			WIDTH_10: m = 13'h03ff;
			WIDTH_13: m = 13'h1fff;
			default:  m = 13'h1fff;
		endcase
		return m;
	endfunction

endpackage

/* rtl/cbp_front.sv */
// front end: config registers, bit accumulator and per-item result count
module cbp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  cbp_pkg::item_beat_t             item,
	output logic                            push,
	output cbp_pkg::entry_t                 push_entry
);

	cbp_pkg::width_mode_t              width_q;
	cbp_pkg::dir_t                     dir_q;
	logic [cbp_pkg::ACC_W-1:0]         acc_q;
	logic [cbp_pkg::COUNT_W-1:0]       cnt_q;

	logic [3:0]                        w;
	logic [cbp_pkg::COEF_W-1:0]        coef;
	logic [cbp_pkg::ACC_W-1:0]         combined;
	logic [cbp_pkg::ACC_W-1:0]         left_bits;
	logic [cbp_pkg::COUNT_W-1:0]       total;
	logic [cbp_pkg::COUNT_W-1:0]       left_cnt;
	logic [cbp_pkg::COUNT_W-1:0]       ucnt;
	logic [cbp_pkg::ACC_W-1:0]         uacc;
	logic [cbp_pkg::NRES_W-1:0]        nres;
	logic                              over;
	logic                              last;
	logic                              accept;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid && !item_stall;
	assign last      = item.stream_last_in;
	assign w         = cbp_pkg::width_bits(width_q);
	assign coef      = item.data_in[cbp_pkg::COEF_W-1:0] & cbp_pkg::coef_mask(width_q);
	assign over      = (cnt_q >= {1'b0, w});
	assign ucnt      = over ? '0 : cnt_q;
	assign uacc      = over ? '0 : acc_q;

	always_comb begin
		combined  = '0;
		total     = '0;
		left_cnt  = '0;
		left_bits = '0;
		nres      = '0;
		if (dir_q == cbp_pkg::DIR_PACK) begin
			combined  = acc_q | ({7'd0, coef} << cnt_q[2:0]);
			total     = {2'd0, cnt_q[2:0]} + {1'b0, w};
			left_cnt  = {2'd0, total[2:0]};
			left_bits = combined >> {total[4:3], 3'd0};
			nres      = {2'd0, total[4:3]} + {3'd0, (last && (total[2:0] != 3'd0))};
		end else begin
			combined = uacc | ({12'd0, item.data_in[7:0]} << ucnt);
			total    = ucnt + 5'd8;
			case (width_q)
				cbp_pkg::WIDTH_1: begin
					nres      = 4'd8;
					left_cnt  = '0;
					left_bits = '0;
				end
				cbp_pkg::WIDTH_4: begin
					nres      = 4'd2;
					left_cnt  = total - 5'd8;
					left_bits = combined >> 8;
				end
				cbp_pkg::WIDTH_10: begin
					if (total >= 5'd10) begin
						nres      = 4'd1;
						left_cnt  = total - 5'd10;
						left_bits = combined >> 10;
					end else begin
						nres      = 4'd0;
						left_cnt  = total;
						left_bits = combined;
					end
				end
				default: begin
					if (total >= 5'd13) begin
						nres      = 4'd1;
						left_cnt  = total - 5'd13;
						left_bits = combined >> 13;
					end else begin
						nres      = 4'd0;
						left_cnt  = total;
						left_bits = combined;
					end
				end
			endcase
		end
	end

	assign push            = accept;
	assign push_entry.bits = combined;
	assign push_entry.nres = nres;
	assign push_entry.mode = width_q;
	assign push_entry.dir  = dir_q;
	assign push_entry.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cbp_pkg::WIDTH_13;
			dir_q   <= cbp_pkg::DIR_PACK;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cbp_pkg::REG_WIDTH_MODE) begin
				width_q <= cbp_pkg::width_mode_t'(cfg_data);
				acc_q   <= '0;
				cnt_q   <= '0;
			end else if (cfg_index == cbp_pkg::REG_DIRECTION) begin
				dir_q <= cbp_pkg::dir_t'(cfg_data[0]);
				acc_q <= '0;
				cnt_q <= '0;
			end
		end else if (accept) begin
			if (last) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= left_bits;
				cnt_q <= left_cnt;
			end
		end
	end

endmodule

/* rtl/cbp_queue.sv */
// small fifo of classified items between front and back
module cbp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cbp_pkg::entry_t   push_entry,
	output logic              full,
	output logic              head_valid,
	output cbp_pkg::entry_t   head,
	input  logic              pop
);

	cbp_pkg::entry_t                 mem [cbp_pkg::QDEPTH];
	logic [cbp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [cbp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [cbp_pkg::QPTR_W:0]        count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (count_q == (cbp_pkg::QPTR_W+1)'(cbp_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/cbp_back.sv */
// back end: serializes queued items, one result per unstalled cycle
module cbp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  cbp_pkg::entry_t        head,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output cbp_pkg::result_beat_t  result
);

	logic [cbp_pkg::ACC_W-1:0]   cur_bits_q;
	logic [cbp_pkg::NRES_W-1:0]  cur_n_q;
	cbp_pkg::width_mode_t        cur_mode_q;
	cbp_pkg::dir_t               cur_dir_q;
	logic                        cur_last_q;
	logic                        result_valid_q;
	cbp_pkg::result_beat_t       result_q;

	logic                        out_space;
	logic                        emit;
	logic                        final_one;
	logic [3:0]                  shamt;
	logic [cbp_pkg::COEF_W-1:0]  value;

	assign out_space = !result_valid_q || !result_stall;
	assign emit      = (cur_n_q != '0) && out_space;
	assign final_one = (cur_n_q == 4'd1);
	assign pop       = head_valid && ((cur_n_q == '0) || (final_one && emit));

	always_comb begin
		if (cur_dir_q == cbp_pkg::DIR_PACK) begin
			shamt = 4'd8;
			value = {5'd0, cur_bits_q[7:0]};
		end else begin
			shamt = cbp_pkg::width_bits(cur_mode_q);
			value = cur_bits_q[cbp_pkg::COEF_W-1:0] & cbp_pkg::coef_mask(cur_mode_q);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bits_q <= head.bits;
			cur_mode_q <= head.mode;
			cur_dir_q  <= head.dir;
			cur_last_q <= head.last;
		end else if (emit) begin
			cur_bits_q <= cur_bits_q >> shamt;
		end
		if (emit) begin
			result_q.data_out        <= value;
			result_q.run_end         <= final_one;
			result_q.stream_last_out <= final_one && cur_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_n_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_n_q <= head.nres;
			end else if (emit) begin
				cur_n_q <= cur_n_q - 1'b1;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/coefficient_bit_packer_unit.sv */
// coefficient bit packer top level: front end, item queue and result serializer
// throughput: one item per cycle while each item gives at most one result and the
//   output is not stalled; an item giving k results holds the serializer until all
//   are out (pack up to 3, unpack up to 8)
// a 4-entry queue absorbs bursts, so items keep flowing while the serializer drains
// reset: arst_n clears the accumulator, queue and output; width is 13 bits, mode is pack
module coefficient_bit_packer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes, always ready; a width or direction write restarts bit alignment
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// coefficient or byte beats in
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cbp_pkg::item_beat_t             item,
	// byte or coefficient beats out
	output logic                            result_valid,
	input  logic                            result_stall,
	output cbp_pkg::result_beat_t           result
);

	logic              push;
	cbp_pkg::entry_t   push_entry;
	logic              q_full;
	logic              head_valid;
	cbp_pkg::entry_t   head;
	logic              pop;

	// input is held off only when the queue is full
	assign item_stall = q_full;

	// front: merges each item into the accumulator and works out its result count
	cbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	cbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: shifts out bytes or coefficients into a registered output beat
	cbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* rtl/cbp_checker.sv */
// port-level checks for the coefficient bit packer, bound to the top level
module cbp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  cbp_pkg::result_beat_t           result
);

	cbp_pkg::dir_t dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= cbp_pkg::DIR_PACK;
		end else if (cfg_valid && cfg_ready && (cfg_index == cbp_pkg::REG_DIRECTION)) begin
			dir_q <= cbp_pkg::dir_t'(cfg_data[0]);
		end
	end

	// a stalled result beat stays up
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// the end of a stream is always the end of an item's run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stream_last_out |-> result.run_end)
		else $error("stream end without run end");

	// packed output is a byte
	a_pack_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (dir_q == cbp_pkg::DIR_PACK) |-> (result.data_out[12:8] == 5'd0))
		else $error("packed output wider than a byte");

endmodule

bind coefficient_bit_packer_unit cbp_checker u_cbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
